// ===== hw/rtl/lnr_pkg.sv =====
// Shared types, constants and helper functions of the layer normalization block.
// Used by every other file of the block; depends on nothing.
package lnr_pkg;

  localparam int DATA_BITS  = 16;
  localparam int SUM_BITS   = 26;
  localparam int LEN_BITS   = 10;
  localparam int EPS_BITS   = 24;
  localparam int CFG_BITS   = 24;
  localparam int IDX_BITS   = 1;
  localparam int OUT_LANES  = 8;
  localparam int LANE_BITS  = 3;
  localparam int CNT_BITS   = 4;
  localparam int DEV_BITS   = 28;
  localparam int MAG_BITS   = 27;
  localparam int ACC_BITS   = 60;
  localparam int DIV_N_BITS = 60;
  localparam int DIV_D_BITS = 34;
  localparam int ROOT_BITS  = 29;
  localparam int RAD_BITS   = 58;
  localparam int NORM_BITS  = 42;
  localparam int PROD_BITS  = 56;
  localparam int Y_BITS     = 60;
  localparam int WORD_BITS  = 3 * DATA_BITS;

  localparam logic [IDX_BITS-1:0]   REG_ROW_LENGTH = 1'd0;
  localparam logic [IDX_BITS-1:0]   REG_EPSILON    = 1'd1;
  localparam logic [LEN_BITS-1:0]   ROW_LENGTH_RST = 10'd512;
  localparam logic [EPS_BITS-1:0]   EPSILON_RST    = 24'd168;
  localparam logic [ROOT_BITS-1:0]  INV_MAX        = 29'h1FFF_FFFF;
  localparam logic [NORM_BITS-2:0]  NORM_CLAMP     = 41'h100_0000_0000;
  localparam logic [DIV_N_BITS-1:0] INV_NUMER      = 60'h100_0000_0000_0000;

  typedef enum logic [4:0] {
    ST_LOAD, ST_VAR_RD, ST_VAR_DEV, ST_VAR_SQ, ST_CUBE1, ST_CUBE2,
    ST_DIV_VAR, ST_WAIT_VAR, ST_DIV_INV, ST_WAIT_INV, ST_SQRT, ST_WAIT_SQRT,
    ST_GRP, ST_OUT_RD, ST_OUT_DEV, ST_OUT_MUL, ST_OUT_DIV, ST_WAIT_NORM,
    ST_PP_LO, ST_PP_HI, ST_SUM, ST_LANE, ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_N_BITS-1:0] dividend;
    logic [DIV_D_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_N_BITS-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                start;
    logic [RAD_BITS-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] root;
  } sqrt_rsp_t;

  // Clamp a wide signed value into the signed output range.
  function automatic logic [DATA_BITS-1:0] sat_out(input logic signed [33:0] y);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd32767;
    lo = -34'sd32768;
    if (y > hi) begin
      return DATA_BITS'(hi);
    end else if (y < lo) begin
      return DATA_BITS'(lo);
    end
    return y[DATA_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/lnr_if.sv =====
// Valid/ready channel interfaces for row elements and normalized results.
// Depends on lnr_pkg.
interface lnr_elem_if;
  import lnr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] sample;
  logic [DATA_BITS-1:0] gain;
  logic [DATA_BITS-1:0] bias;
  modport source (output valid, sample, gain, bias, input ready);
  modport sink (input valid, sample, gain, bias, output ready);
endinterface

interface lnr_result_if;
  import lnr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] norm_lane0;
  logic [DATA_BITS-1:0] norm_lane1;
  logic [DATA_BITS-1:0] norm_lane2;
  logic [DATA_BITS-1:0] norm_lane3;
  logic [DATA_BITS-1:0] norm_lane4;
  logic [DATA_BITS-1:0] norm_lane5;
  logic [DATA_BITS-1:0] norm_lane6;
  logic [DATA_BITS-1:0] norm_lane7;
  logic [CNT_BITS-1:0]  lanes_valid;
  logic                 row_end;
  modport source (output valid, norm_lane0, norm_lane1, norm_lane2, norm_lane3,
                  norm_lane4, norm_lane5, norm_lane6, norm_lane7, lanes_valid,
                  row_end, input ready);
  modport sink (input valid, norm_lane0, norm_lane1, norm_lane2, norm_lane3,
                norm_lane4, norm_lane5, norm_lane6, norm_lane7, lanes_valid,
                row_end, output ready);
endinterface

// ===== hw/rtl/lnr_store.sv =====
// Row buffer holding sample, gain and bias of each element position.
// Single write port, single registered read port; depends on lnr_pkg.
module lnr_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [lnr_pkg::WORD_BITS-1:0] wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [lnr_pkg::WORD_BITS-1:0] rd_data
);
  import lnr_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/lnr_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the variance, inverse and per-element scaling steps; depends on lnr_pkg.
module lnr_divider (
  input  logic                clk,
  input  logic                rst,
  input  lnr_pkg::div_req_t   req,
  output lnr_pkg::div_rsp_t   rsp
);
  import lnr_pkg::*;

  logic [DIV_N_BITS-1:0] work;
  logic [DIV_D_BITS-1:0] rem;
  logic [DIV_D_BITS-1:0] dsr;
  logic [5:0]            cnt;
  logic                  busy;
  logic                  done;
  logic [DIV_D_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem, work[DIV_N_BITS-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_N_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      rem  <= '0;
      dsr  <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? DIV_D_BITS'(trial - {1'b0, dsr}) : trial[DIV_D_BITS-1:0];
      work <= {work[DIV_N_BITS-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

  property p_no_restart;
    @(posedge clk) disable iff (rst) busy |-> !req.start;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("divider started while busy");

  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without finishing");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt < 6'(DIV_N_BITS))
    else $error("divider count out of range");

endmodule

// ===== hw/rtl/lnr_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
// Gives floor(sqrt(radicand)); depends on lnr_pkg.
module lnr_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  lnr_pkg::sqrt_req_t  req,
  output lnr_pkg::sqrt_rsp_t  rsp
);
  import lnr_pkg::*;

  logic [RAD_BITS-1:0]  rad;
  logic [31:0]          rem;
  logic [ROOT_BITS-1:0] root;
  logic [4:0]           cnt;
  logic                 busy;
  logic                 done;
  logic [31:0]          rem_t;
  logic [31:0]          trial;
  logic                 fits;

  assign rem_t = {rem[29:0], rad[RAD_BITS-1:RAD_BITS-2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(ROOT_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_BITS-3:0], 2'b00};
      rem  <= fits ? rem_t - trial : rem_t;
      root <= {root[ROOT_BITS-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("square root started while busy");

  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("square root done without finishing");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem[31:30] == 2'b00)
    else $error("square root remainder overflow");

endmodule

// ===== hw/rtl/layer_norm_row.sv =====
// Layer normalization of one row: sequencer, datapath and output register.
// Depends on lnr_pkg, lnr_if, lnr_store, lnr_divider and lnr_isqrt.
//
// Elements of a row arrive one per request together with the gain and bias of
// their position and are taken one per cycle while the block loads. When the
// configured row length is reached the block stops taking requests and runs a
// small sequencer over a shared restoring divider (one bit per cycle) and a
// bit-serial square root. For a row of n elements the work after the last
// element is the variance pass, two divisions and one root, then the scaling
// pass, which the per-element divider run dominates, with one result per group
// of up to eight lanes. The last result of a row is marked by row_end; the next
// row may load while it still waits. Statistics are exact: the deviation
// n*x - S is kept unscaled, the variance is floor(sum(dev^2)/n^3) in units of
// 2^-24, and the inverse root is floor(2^28/sqrt(var + epsilon)), saturating
// when the sum is zero. Results are gain times normalized deviation rounded
// half up to Q4.12, plus bias, saturated to 16 bits. Configuration may be
// written only while idle.
module layer_norm_row #(
  parameter int MAX_ROW = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [lnr_pkg::IDX_BITS-1:0]   wr_index,
  input  logic [lnr_pkg::CFG_BITS-1:0]   wr_data,
  lnr_elem_if.sink                       elem,
  lnr_result_if.source                   result
);
  import lnr_pkg::*;

  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

  state_t state, state_next;

  // Configuration registers.
  logic [LEN_BITS-1:0] row_length;
  logic [EPS_BITS-1:0] epsilon;

  // Load-side state.
  logic [SUM_BITS-1:0] running_sum;
  logic [LEN_BITS-1:0] element_count;

  // Row statistics and pass counters.
  logic [LEN_BITS-1:0]        n_reg;
  logic signed [SUM_BITS-1:0] s_reg;
  logic [LEN_BITS-1:0]        k;
  logic [LEN_BITS-1:0]        base;
  logic [LANE_BITS-1:0]       lane;
  logic [ACC_BITS-1:0]        sq_acc;
  logic [19:0]                n2;
  logic [29:0]                n3;
  logic [DIV_D_BITS-1:0]      v_reg;
  logic [RAD_BITS-1:0]        q_reg;
  logic [ROOT_BITS-1:0]       r_reg;

  // Per-element datapath registers.
  logic signed [DEV_BITS-1:0]  d_reg;
  logic signed [DATA_BITS-1:0] g_reg;
  logic signed [DATA_BITS-1:0] b_reg;
  logic [PROD_BITS-1:0]        p_reg;
  logic                        neg_reg;
  logic signed [NORM_BITS-1:0] norm_reg;
  logic signed [37:0]          pp_lo;
  logic signed [36:0]          pp_hi;
  logic signed [Y_BITS-1:0]    y_reg;
  logic [DATA_BITS-1:0]        lanes [OUT_LANES];

  // Output register.
  logic                 o_valid;
  logic [DATA_BITS-1:0] o_lanes [OUT_LANES];
  logic [CNT_BITS-1:0]  o_cnt;
  logic                 o_end;

  // Memory ports and shared units.
  logic                 st_wr;
  logic [AW-1:0]        st_wr_addr;
  logic [WORD_BITS-1:0] st_rd;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  sqrt_req_t            sqrt_req;
  sqrt_rsp_t            sqrt_rsp;

  // Load-side arithmetic.
  logic                 accept;
  logic [LEN_BITS-1:0]  idx;
  logic [LEN_BITS-1:0]  len;
  logic [LEN_BITS:0]    count_plus;
  logic                 row_done;
  logic [SUM_BITS-1:0]  sum_next;

  // Scaling-pass helpers.
  logic signed [DEV_BITS-1:0]  dev;
  logic [MAG_BITS-1:0]         d_mag;
  logic [LEN_BITS:0]           k_plus;
  logic                        last_elem;
  logic                        out_free;
  logic [NORM_BITS-2:0]        norm_mag;
  logic signed [33:0]          y_out;

  assign accept = elem.valid && elem.ready;

  always_comb begin
    if (element_count >= LEN_BITS'(MAX_ROW)) begin
      idx = LEN_BITS'(MAX_ROW - 1);
    end else begin
      idx = element_count;
    end
    if (row_length == '0) begin
      len = LEN_BITS'(1);
    end else if (row_length > LEN_BITS'(MAX_ROW)) begin
      len = LEN_BITS'(MAX_ROW);
    end else begin
      len = row_length;
    end
  end

  assign count_plus = {1'b0, idx} + (LEN_BITS+1)'(1);
  assign row_done   = count_plus >= {1'b0, len};
  assign sum_next   = running_sum +
                      SUM_BITS'($signed(elem.sample));
  assign st_wr      = accept;
  assign st_wr_addr = idx[AW-1:0];

  // Deviation times n, from the element just read out of the row buffer.
  assign dev = DEV_BITS'($signed({1'b0, n_reg}) *
                         $signed(st_rd[WORD_BITS-1 -: DATA_BITS])) -
               DEV_BITS'(s_reg);
  assign d_mag     = d_reg[DEV_BITS-1] ? MAG_BITS'(-d_reg) : MAG_BITS'(d_reg);
  assign k_plus    = {1'b0, k} + (LEN_BITS+1)'(1);
  assign last_elem = k_plus >= {1'b0, n_reg};
  assign out_free  = !o_valid || result.ready;
  assign norm_mag  = (div_rsp.quotient > DIV_N_BITS'(NORM_CLAMP)) ?
                     NORM_CLAMP : div_rsp.quotient[NORM_BITS-2:0];
  assign y_out     = 34'(y_reg >>> 28) + 34'(b_reg);

  lnr_store #(
    .DEPTH (MAX_ROW),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr),
    .wr_addr (st_wr_addr),
    .wr_data ({elem.sample, elem.gain, elem.bias}),
    .rd_addr (k[AW-1:0]),
    .rd_data (st_rd)
  );

  lnr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lnr_isqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (accept && row_done) state_next = ST_VAR_RD;
      ST_VAR_RD:    state_next = ST_VAR_DEV;
      ST_VAR_DEV:   state_next = ST_VAR_SQ;
      ST_VAR_SQ:    state_next = last_elem ? ST_CUBE1 : ST_VAR_RD;
      ST_CUBE1:     state_next = ST_CUBE2;
      ST_CUBE2:     state_next = ST_DIV_VAR;
      ST_DIV_VAR:   state_next = ST_WAIT_VAR;
      ST_WAIT_VAR:  if (div_rsp.done) state_next = ST_DIV_INV;
      ST_DIV_INV:   state_next = (v_reg == '0) ? ST_GRP : ST_WAIT_INV;
      ST_WAIT_INV:  if (div_rsp.done) state_next = ST_SQRT;
      ST_SQRT:      state_next = ST_WAIT_SQRT;
      ST_WAIT_SQRT: if (sqrt_rsp.done) state_next = ST_GRP;
      ST_GRP:       state_next = ST_OUT_RD;
      ST_OUT_RD:    state_next = ST_OUT_DEV;
      ST_OUT_DEV:   state_next = ST_OUT_MUL;
      ST_OUT_MUL:   state_next = ST_OUT_DIV;
      ST_OUT_DIV:   state_next = ST_WAIT_NORM;
      ST_WAIT_NORM: if (div_rsp.done) state_next = ST_PP_LO;
      ST_PP_LO:     state_next = ST_PP_HI;
      ST_PP_HI:     state_next = ST_SUM;
      ST_SUM:       state_next = ST_LANE;
      ST_LANE: begin
        if (last_elem || lane == LANE_BITS'(OUT_LANES - 1)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_OUT_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = last_elem ? ST_LOAD : ST_GRP;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    elem.ready        = 1'b0;
    div_req.start     = 1'b0;
    div_req.dividend  = DIV_N_BITS'(p_reg);
    div_req.divisor   = DIV_D_BITS'(n_reg);
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = q_reg;
    unique case (state)
      ST_LOAD: elem.ready = 1'b1;
      ST_DIV_VAR: begin
        div_req.start    = 1'b1;
        div_req.dividend = sq_acc;
        div_req.divisor  = DIV_D_BITS'(n3);
      end
      ST_DIV_INV: begin
        div_req.start    = (v_reg != '0);
        div_req.dividend = INV_NUMER;
        div_req.divisor  = v_reg;
      end
      ST_SQRT:    sqrt_req.start = 1'b1;
      ST_OUT_DIV: div_req.start  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      row_length    <= ROW_LENGTH_RST;
      epsilon       <= EPSILON_RST;
      running_sum   <= '0;
      element_count <= '0;
      o_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        unique case (wr_index)
          REG_ROW_LENGTH: row_length <= wr_data[LEN_BITS-1:0];
          REG_EPSILON:    epsilon    <= wr_data[EPS_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (row_done) begin
          running_sum   <= '0;
          element_count <= '0;
        end else begin
          running_sum   <= sum_next;
          element_count <= count_plus[LEN_BITS-1:0];
        end
      end
      if (state == ST_EMIT && out_free) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Datapath registers; the sequencer state selects which one moves.
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        if (accept && row_done) begin
          n_reg  <= count_plus[LEN_BITS-1:0];
          s_reg  <= $signed(sum_next);
          k      <= '0;
          sq_acc <= '0;
        end
      end
      ST_VAR_DEV: d_reg <= dev;
      ST_VAR_SQ: begin
        sq_acc <= sq_acc + ACC_BITS'(d_mag * d_mag);
        k      <= k_plus[LEN_BITS-1:0];
      end
      ST_CUBE1: n2 <= n_reg * n_reg;
      ST_CUBE2: n3 <= n2 * n_reg;
      ST_WAIT_VAR: begin
        if (div_rsp.done) begin
          v_reg <= div_rsp.quotient[DIV_D_BITS-1:0] + DIV_D_BITS'(epsilon);
        end
      end
      ST_DIV_INV: begin
        base <= '0;
        if (v_reg == '0) begin
          r_reg <= INV_MAX;
        end
      end
      ST_WAIT_INV: begin
        if (div_rsp.done) begin
          q_reg <= div_rsp.quotient[RAD_BITS-1:0];
        end
      end
      ST_WAIT_SQRT: begin
        if (sqrt_rsp.done) begin
          r_reg <= sqrt_rsp.root;
        end
      end
      ST_GRP: begin
        k    <= base;
        lane <= '0;
        for (int i = 0; i < OUT_LANES; i++) begin
          lanes[i] <= '0;
        end
      end
      ST_OUT_DEV: begin
        d_reg <= dev;
        g_reg <= $signed(st_rd[WORD_BITS-DATA_BITS-1 -: DATA_BITS]);
        b_reg <= $signed(st_rd[DATA_BITS-1:0]);
      end
      ST_OUT_MUL: begin
        p_reg   <= PROD_BITS'(d_mag * r_reg);
        neg_reg <= d_reg[DEV_BITS-1];
      end
      ST_WAIT_NORM: begin
        if (div_rsp.done) begin
          norm_reg <= neg_reg ? -$signed({1'b0, norm_mag}) : $signed({1'b0, norm_mag});
        end
      end
      ST_PP_LO: pp_lo <= g_reg * $signed({1'b0, norm_reg[20:0]});
      ST_PP_HI: pp_hi <= g_reg * $signed(norm_reg[NORM_BITS-1:21]);
      ST_SUM: begin
        y_reg <= (Y_BITS'(pp_hi) <<< 21) + Y_BITS'(pp_lo) +
                 (Y_BITS'(1) <<< 27);
      end
      ST_LANE: begin
        lanes[lane] <= sat_out(y_out);
        if (!(last_elem || lane == LANE_BITS'(OUT_LANES - 1))) begin
          lane <= lane + LANE_BITS'(1);
          k    <= k_plus[LEN_BITS-1:0];
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          o_lanes <= lanes;
          o_cnt   <= CNT_BITS'(lane) + CNT_BITS'(1);
          o_end   <= last_elem;
          base    <= k_plus[LEN_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  assign result.valid       = o_valid;
  assign result.norm_lane0  = o_lanes[0];
  assign result.norm_lane1  = o_lanes[1];
  assign result.norm_lane2  = o_lanes[2];
  assign result.norm_lane3  = o_lanes[3];
  assign result.norm_lane4  = o_lanes[4];
  assign result.norm_lane5  = o_lanes[5];
  assign result.norm_lane6  = o_lanes[6];
  assign result.norm_lane7  = o_lanes[7];
  assign result.lanes_valid = o_cnt;
  assign result.row_end     = o_end;

  // The shared divider only answers while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_WAIT_VAR || state == ST_WAIT_INV ||
                      state == ST_WAIT_NORM))
    else $error("divider result arrived outside a wait state");

  // The element count never passes the buffer depth.
  a_count: assert property (@(posedge clk) disable iff (rst)
    element_count <= LEN_BITS'(MAX_ROW))
    else $error("element count beyond buffer depth");

  // A result is only loaded once the previous one has left.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && o_valid && !result.ready) |=> $stable(o_cnt))
    else $error("pending result overwritten");

  // The variance and scaling passes never read beyond the row.
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_DEV || state == ST_VAR_DEV) |-> k < n_reg)
    else $error("row pass index beyond row length");

endmodule
